FILE: hw/rtl/lc_pkg.sv
// Shared types and constants for the linear convolution block.
// No dependencies; imported by lc_ctrl, lc_dp and linear_convolution.
package lc_pkg;

    localparam int CNT_W = 6;   // sample counts and loop indexes (depth up to 32)
    localparam int IDX_W = 6;   // output position, up to 62
    localparam int VAL_W = 37;  // full-precision sum

    typedef enum logic [1:0] {
        CMD_LOAD_DATA   = 2'd0,
        CMD_LOAD_KERNEL = 2'd1,
        CMD_COMPUTE     = 2'd2
    } t_cmd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_data;     // store sample in the data memory
        logic             wr_kern;     // store sample in the kernel memory
        logic [CNT_W-1:0] wr_addr;
        logic             rd_en;       // issue one multiply-accumulate
        logic [CNT_W-1:0] rd_i;        // data address
        logic [CNT_W-1:0] rd_j;        // kernel address
        logic             first;       // first product of a term
        logic             term_end;    // last product of a term
        logic             final_term;  // term is the last of the run
        logic [IDX_W-1:0] idx;         // term position
        logic             emit_err;    // emit the empty-sequence result
    } t_dp_cmd;

endpackage

FILE: hw/rtl/lc_dp.sv
// Datapath of the linear convolution block: sample memories, multiplier,
// accumulator and result register. Depends on lc_pkg.
module lc_dp
    import lc_pkg::*;
#(
    parameter int DATA_DEPTH   = 32,
    parameter int KERNEL_DEPTH = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    output logic signed [VAL_W-1:0]        o_value,
    output logic [IDX_W-1:0]               o_index,
    output logic                           o_last,
    output logic                           o_error
);

    localparam int DA_W = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int KA_W = (KERNEL_DEPTH > 1) ? $clog2(KERNEL_DEPTH) : 1;
    localparam int PW   = 2 * SAMPLE_WIDTH;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             term_end;
        logic             final_term;
        logic [IDX_W-1:0] idx;
    } t_tag;

    logic signed [SAMPLE_WIDTH-1:0] r_data_mem [DATA_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_kern_mem [KERNEL_DEPTH];

    logic signed [SAMPLE_WIDTH-1:0] r_d_q;
    logic signed [SAMPLE_WIDTH-1:0] r_k_q;
    logic signed [PW-1:0]           r_prod;
    logic signed [VAL_W-1:0]        r_acc;
    logic signed [VAL_W-1:0]        n_acc;
    t_tag                           r_s1;
    t_tag                           r_s2;

    logic                           r_valid;
    logic signed [VAL_W-1:0]        r_value;
    logic [IDX_W-1:0]               r_index;
    logic                           r_last;
    logic                           r_error;

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_data) begin
            r_data_mem[i_cmd.wr_addr[DA_W-1:0]] <= i_sample;
        end
        if (i_cmd.wr_kern) begin
            r_kern_mem[i_cmd.wr_addr[KA_W-1:0]] <= i_sample;
        end
        if (i_cmd.rd_en) begin
            r_d_q <= r_data_mem[i_cmd.rd_i[DA_W-1:0]];
            r_k_q <= r_kern_mem[i_cmd.rd_j[KA_W-1:0]];
        end
    end

    // Product and accumulator payload.
    always_ff @(posedge i_clk) begin
        r_prod <= r_d_q * r_k_q;
        if (r_s2.vld) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        n_acc = (r_s2.first ? '0 : r_acc) + VAL_W'(r_prod);
    end

    // Tags travel beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1.vld        <= i_cmd.rd_en;
            r_s1.first      <= i_cmd.first;
            r_s1.term_end   <= i_cmd.term_end;
            r_s1.final_term <= i_cmd.final_term;
            r_s1.idx        <= i_cmd.idx;
            r_s2            <= r_s1;
        end
    end

    // Result register: strobe for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_err || (r_s2.vld && r_s2.term_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_value <= '0;
            r_index <= '0;
            r_last  <= 1'b1;
            r_error <= 1'b1;
        end else if (r_s2.vld && r_s2.term_end) begin
            r_value <= n_acc;
            r_index <= r_s2.idx;
            r_last  <= r_s2.final_term;
            r_error <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_index = r_index;
    assign o_last  = r_last;
    assign o_error = r_error;

endmodule

FILE: hw/rtl/lc_ctrl.sv
// Controller of the linear convolution block: sample counts, request
// decode and the multiply-accumulate sequencer. Depends on lc_pkg.
module lc_ctrl
    import lc_pkg::*;
#(
    parameter int DATA_DEPTH   = 32,
    parameter int KERNEL_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_command,
    output logic        o_busy,
    output t_dp_cmd     o_dp
);

    // Drain wait while the last result passes the read, product and result registers.
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_dcnt, n_dcnt;
    logic [CNT_W-1:0] r_kcnt, n_kcnt;
    logic [CNT_W-1:0] r_nd, n_nd;
    logic [CNT_W-1:0] r_nk, n_nk;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_i, n_i;
    logic             r_first, n_first;
    logic [1:0]       r_drain, n_drain;

    logic             accept;
    logic [CNT_W-1:0] imax;
    logic [CNT_W-1:0] k_inc;
    logic [CNT_W-1:0] next_imin;
    logic             term_end;
    logic             final_term;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        imax       = (r_k < r_nd) ? r_k : (r_nd - 1'b1);
        k_inc      = r_k + 1'b1;
        next_imin  = (k_inc >= r_nk) ? (k_inc + 1'b1 - r_nk) : '0;
        term_end   = (r_i == imax);
        final_term = term_end && (r_k == (r_nd + r_nk - 2'd2));
    end

    always_comb begin
        n_state = r_state;
        n_dcnt  = r_dcnt;
        n_kcnt  = r_kcnt;
        n_nd    = r_nd;
        n_nk    = r_nk;
        n_k     = r_k;
        n_i     = r_i;
        n_first = r_first;
        n_drain = r_drain;
        o_dp    = '0;
        o_dp.wr_addr = (i_command == CMD_LOAD_KERNEL) ? r_kcnt : r_dcnt;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_LOAD_DATA: begin
                            if (r_dcnt < CNT_W'(DATA_DEPTH)) begin
                                o_dp.wr_data = 1'b1;
                                n_dcnt       = r_dcnt + 1'b1;
                            end
                        end
                        CMD_LOAD_KERNEL: begin
                            if (r_kcnt < CNT_W'(KERNEL_DEPTH)) begin
                                o_dp.wr_kern = 1'b1;
                                n_kcnt       = r_kcnt + 1'b1;
                            end
                        end
                        CMD_COMPUTE: begin
                            n_dcnt = '0;
                            n_kcnt = '0;
                            if (r_dcnt == '0 || r_kcnt == '0) begin
                                o_dp.emit_err = 1'b1;
                            end else begin
                                n_nd    = r_dcnt;
                                n_nk    = r_kcnt;
                                n_k     = '0;
                                n_i     = '0;
                                n_first = 1'b1;
                                n_state = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_dp.rd_en      = 1'b1;
                o_dp.rd_i       = r_i;
                o_dp.rd_j       = r_k - r_i;
                o_dp.first      = r_first;
                o_dp.term_end   = term_end;
                o_dp.final_term = final_term;
                o_dp.idx        = IDX_W'(r_k);
                if (final_term) begin
                    n_drain = DRAIN_LAST;
                    n_state = ST_DRAIN;
                end else if (term_end) begin
                    n_k     = k_inc;
                    n_i     = next_imin;
                    n_first = 1'b1;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_first = 1'b0;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain - 1'b1;
                if (r_drain == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dcnt  <= '0;
            r_kcnt  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_dcnt  <= n_dcnt;
            r_kcnt  <= n_kcnt;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nd    <= n_nd;
        r_nk    <= n_nk;
        r_k     <= n_k;
        r_i     <= n_i;
        r_first <= n_first;
    end

    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_i <= imax && (r_k - r_i) < r_nk))
        else $error("issue outside the valid index window");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dcnt <= CNT_W'(DATA_DEPTH)) && (r_kcnt <= CNT_W'(KERNEL_DEPTH)))
        else $error("sample count beyond store depth");

    a_compute_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_COMPUTE) |=> (r_dcnt == '0 && r_kcnt == '0))
        else $error("compute did not clear the counts");

    a_err_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp.emit_err |-> (r_state == ST_IDLE && !o_dp.rd_en))
        else $error("error result requested while computing");

    a_run_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && final_term) |=> (r_state == ST_DRAIN))
        else $error("run did not move to drain after final term");

endmodule

FILE: hw/rtl/linear_convolution.sv
// Top level of the linear convolution block.
// Depends on lc_pkg, lc_ctrl and lc_dp.
//
// Usage: a request is taken at a rising edge with i_start high and o_busy
// low. Command 0 stores i_sample as the next data sample, command 1 as the
// next kernel sample; a sample past the store depth is dropped. Loads never
// raise o_busy. Command 2 clears both counts when taken and emits the full
// linear convolution, nd+nk-1 sums of signed products at full precision,
// one per o_valid strobe, the final one with o_last set. Each sum reads
// one overlapping sample pair per cycle, set by the single
// multiply-accumulate unit fed from one read port per sample memory; a run
// reads every overlapping pair (up to 1024 pairs) in turn. o_busy holds
// for the whole run. A compute with either store empty returns, in the
// next cycle, one result with value 0, index 0, o_last and o_error set.
// Results last exactly one cycle each; the receiver cannot stall them.
// Reset clears the counts and the sequencer; memory contents are kept
// and never read before they are written again.
module linear_convolution
    import lc_pkg::*;
#(
    parameter int DATA_DEPTH   = 32,
    parameter int KERNEL_DEPTH = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_command,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    output logic signed [VAL_W-1:0]        o_value,
    output logic [IDX_W-1:0]               o_index,
    output logic                           o_last,
    output logic                           o_error
);

    t_dp_cmd dp_cmd;

    // Decode requests, keep the counts and walk the sample pairs.
    lc_ctrl #(
        .DATA_DEPTH   (DATA_DEPTH),
        .KERNEL_DEPTH (KERNEL_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .o_busy    (o_busy),
        .o_dp      (dp_cmd)
    );

    // Store samples, multiply, accumulate and drive the result strobe.
    lc_dp #(
        .DATA_DEPTH   (DATA_DEPTH),
        .KERNEL_DEPTH (KERNEL_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .o_value  (o_value),
        .o_index  (o_index),
        .o_last   (o_last),
        .o_error  (o_error)
    );

endmodule
